FILE: rtl/aep_pkg.sv
// Shared types, tables and constants for the acceleration enrichment pulse block.
`default_nettype none

package aep_pkg;

    localparam int unsigned PULSE_W     = 14;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned THR_W       = 16;
    localparam int unsigned POS_W       = 10;
    localparam int unsigned DT_W        = 16;
    localparam int unsigned TEMP_W      = 12;
    localparam int unsigned GAIN_W      = 4;
    localparam int unsigned BUCKET_W    = 4;
    localparam int unsigned TABLE_SLOTS = 16;

    // Divider sizing: the widest dividend is held_pulse * decay_count
    localparam int unsigned DVD_W  = PULSE_W + COUNT_W;
    localparam int unsigned DVS_W  = DT_W;
    localparam int unsigned STEP_W = 5;

    localparam logic [STEP_W-1:0] RATE_STEPS  = STEP_W'(POS_W);
    localparam logic [STEP_W-1:0] TAPER_STEPS = STEP_W'(DVD_W);

    localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

    // Configuration register indexes
    localparam logic REG_RATE_THRESHOLD = 1'b0;
    localparam logic REG_TAPER_LENGTH   = 1'b1;

    localparam logic [THR_W-1:0]   RATE_THRESHOLD_RST = 16'd5;
    localparam logic [COUNT_W-1:0] TAPER_LENGTH_RST   = 8'd8;

    // Coolant axis, padded past the eighth entry
    localparam logic signed [TEMP_W-1:0] TEMP_AXIS [TABLE_SLOTS] = '{
        -12'sd400, -12'sd100, 12'sd0, 12'sd200, 12'sd400, 12'sd700, 12'sd900, 12'sd1100,
        12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047,
        12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047
    };

    localparam logic [GAIN_W-1:0] BUCKET_GAIN [TABLE_SLOTS] = '{
        4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
    };

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/accel_enrichment_pulse.sv
// Top level of the throttle acceleration enrichment pulse generator.
//
//  channel | direction | ports                          | contents
//  --------+-----------+--------------------------------+-------------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser | one throttle sample event word
//  m_      | out       | m_tvalid m_tready m_tdata      | one enrichment pulse word per event
//  cfg_    | in        | cfg_we cfg_index cfg_wdata     | rate_threshold, taper_length
//
// A result word is registered and shown in S_OUT: straight after S_IDLE for clear mode or
// zero elapsed time, after S_RATE and S_DECIDE when only the rate is compared, and after
// S_RATE, S_DECIDE and S_TAPER when the pulse tapers: the shared divider gives one quotient
// bit per cycle (10 bits for the rate, 22 bits for the taper quotient). With m_tready high
// the next event word is taken in the cycle after the result word.
// One event is in flight at a time; s_tready is low until its result word is taken.
// A stalled m_tready holds the result word and the block with it.
// aresetn is synchronous: it clears the sequencer, the held pulse, the decay counter
// and loads the register reset values.
`default_nettype none

module accel_enrichment_pulse #(
    parameter int unsigned BUCKETS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [9:0] throttle_now, [19:10] throttle_before, [35:20] elapsed_ms, [47:36] coolant_temp
    input  wire logic [47:0] s_tdata,
    // [0] mode
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [13:0] enrich_pulse, [15:14] zero
    output logic      [15:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import aep_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RATE   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_TAPER  = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [THR_W-1:0]   thr_reg;
    logic [COUNT_W-1:0] taper_reg;
    logic [PULSE_W-1:0] held_reg, held_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [PULSE_W-1:0] result_reg, result_next;
    logic signed [TEMP_W-1:0] temp_reg;

    logic [POS_W-1:0]  thr_now, thr_before, delta, rate;
    logic [DT_W-1:0]   dt;
    logic              in_mode, accept;
    logic [BUCKET_W-1:0] bucket;
    logic [GAIN_W-1:0]   gain;
    logic [PULSE_W-1:0]  fire_pulse;
    logic [COUNT_W-1:0]  count_dec;
    logic [DVD_W-1:0]    taper_prod;
    logic [DVD_W-1:0]    quo;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign in_mode    = s_tuser;
    assign thr_now    = s_tdata[9:0];
    assign thr_before = s_tdata[19:10];
    assign dt         = s_tdata[35:20];
    assign accept     = s_tvalid && s_tready;
    assign delta      = (thr_now > thr_before) ? POS_W'(thr_now - thr_before) : '0;

    assign quo  = div_rsp.quotient;
    assign rate = quo[POS_W-1:0];

    // First bucket whose upper axis edge lies above the temperature
    always_comb begin
        bucket = BUCKET_W'(BUCKETS - 1);
        for (int i = BUCKETS - 2; i >= 0; i--) begin
            if (temp_reg < TEMP_AXIS[i+1]) begin
                bucket = BUCKET_W'(i);
            end
        end
    end

    assign gain       = BUCKET_GAIN[bucket];
    assign fire_pulse = PULSE_W'(rate * gain);
    assign count_dec  = count_reg - 1'b1;
    assign taper_prod = held_reg * count_dec;

    always_comb begin
        state_next  = state_reg;
        held_next   = held_reg;
        count_next  = count_reg;
        result_next = result_reg;
        div_req     = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_mode) begin
                        held_next   = '0;
                        count_next  = '0;
                        result_next = '0;
                        state_next  = S_OUT;
                    end else if (dt == '0) begin
                        result_next = '0;
                        state_next  = S_OUT;
                    end else begin
                        // left-align the delta so its top bit enters first
                        div_req.start    = 1'b1;
                        div_req.steps    = RATE_STEPS;
                        div_req.dividend = {delta, (DVD_W - POS_W)'(0)};
                        div_req.divisor  = dt;
                        state_next       = S_RATE;
                    end
                end
            end
            S_RATE: begin
                if (div_rsp.done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if ({(THR_W - POS_W)'(0), rate} > thr_reg) begin
                    held_next   = fire_pulse;
                    count_next  = taper_reg;
                    result_next = fire_pulse;
                    state_next  = S_OUT;
                end else if (count_reg != '0) begin
                    count_next       = count_dec;
                    div_req.start    = 1'b1;
                    div_req.steps    = TAPER_STEPS;
                    div_req.dividend = taper_prod;
                    div_req.divisor  = {(DVS_W - COUNT_W)'(0), taper_reg};
                    state_next       = S_TAPER;
                end else begin
                    held_next   = '0;
                    result_next = '0;
                    state_next  = S_OUT;
                end
            end
            S_TAPER: begin
                if (div_rsp.done) begin
                    // saturate when the taper was shortened mid-decay
                    result_next = (quo[DVD_W-1:PULSE_W] != '0) ? PULSE_MAX
                                                                : quo[PULSE_W-1:0];
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            count_reg <= '0;
            thr_reg   <= RATE_THRESHOLD_RST;
            taper_reg <= TAPER_LENGTH_RST;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
            count_reg <= count_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_RATE_THRESHOLD: thr_reg <= cfg_wdata;
                    REG_TAPER_LENGTH: begin
                        // a zero length is stored as one
                        taper_reg <= (cfg_wdata[COUNT_W-1:0] == '0) ? COUNT_W'(1)
                                                                     : cfg_wdata[COUNT_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        if (accept) begin
            temp_reg <= s_tdata[47:36];
        end
    end

    aep_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {2'b00, result_reg};

endmodule

`default_nettype wire

FILE: rtl/aep_div.sv
// Restoring divider, one quotient bit per cycle, dividend taken from its top bits.
`default_nettype none

module aep_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire aep_pkg::div_req_t req,
    output aep_pkg::div_rsp_t      rsp
);
    import aep_pkg::*;

    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0] rem_sh;
    logic           ge;

    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        // remainder stays below the divisor, so it fits DVS_W bits
        rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            dvd_reg <= req.dividend;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire
